@@ hw/rtl/s2x_pkg.sv @@
// shared types, constants and the scale2x rule for the 2x upscaler
package s2x_pkg;

    localparam int PIXEL_BITS_C = 32;
    localparam int MAX_DIM_C    = 4096;
    localparam int FIFO_DEPTH_C = 4;

    localparam int PIX_W   = 32;
    localparam int POS_W   = 12;
    localparam int DIM_REG_W = 13;
    localparam int IN_W    = 3 * PIX_W;
    localparam int OUT_W   = 2 * POS_W + 4 * PIX_W;

    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd320;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd200;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [PIX_W-1:0] bottom_right;
        logic [PIX_W-1:0] bottom_left;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] top_left;
    } t_quad;

    typedef struct packed {
        logic             frame_done;
        logic [PIX_W-1:0] bottom_right;
        logic [PIX_W-1:0] bottom_left;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] top_left;
        logic [POS_W-1:0] src_row;
        logic [POS_W-1:0] src_column;
    } t_result;

    // e centre, a above, b right, c left, d below
    function automatic t_quad scale2x(input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
                                      input logic [PIX_W-1:0] d);
        t_quad q;
        q.top_left     = (c == a && c != d && a != b) ? a : e;
        q.top_right    = (a == b && a != c && b != d) ? b : e;
        q.bottom_left  = (d == c && d != b && c != a) ? c : e;
        q.bottom_right = (b == d && b != a && d != c) ? d : e;
        return q;
    endfunction

endpackage

@@ hw/rtl/scale2x_pixel_upscaler_top.sv @@
// top level of the scale2x 2x pixel upscaler with register port
//
//  port group   dir   role
//  s_axis_*     in    source column sample: centre, above, below pixel
//  m_axis_*     out   expanded 2x2 block with its source position
//  p*           in    register writes and reads (width, height)
//
// one input word per cycle while the result queue has two free slots; a word on
// the last column of a row yields two result words (one when the width is 1),
// the first of a wider row none, all others one
// the result queue holds four words; input is taken while two slots are free
// synchronous active-low reset: counters cleared, width 320, height 200
// a stalled output holds its word; input stops once three words are queued
module scale2x_pixel_upscaler_top
    import s2x_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_C,
    parameter int MAX_DIM    = MAX_DIM_C
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // center_pixel, above_pixel, below_pixel
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // src_column, src_row, top_left, top_right,
                                             // bottom_left, bottom_right
    output logic             m_axis_tlast,   // frame_done
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;

    logic [DIM_REG_W-1:0]  r_width;
    logic [DIM_REG_W-1:0]  r_height;
    logic [DIM_W-1:0]      w_last;
    logic [DIM_W-1:0]      h_last;

    logic [PIXEL_BITS-1:0] r_left_center, n_left_center;
    logic [PIXEL_BITS-1:0] r_mid_center, n_mid_center;
    logic [PIXEL_BITS-1:0] r_mid_above, n_mid_above;
    logic [PIXEL_BITS-1:0] r_mid_below, n_mid_below;
    logic [CNT_W-1:0]      r_col, n_col;
    logic [CNT_W-1:0]      r_row, n_row;
    logic                  r_window_valid, n_window_valid;

    logic                  in_acc;
    logic                  first_row;
    logic                  last_row;
    logic                  last_col;
    logic [PIXEL_BITS-1:0] e;
    logic [PIXEL_BITS-1:0] a;
    logic [PIXEL_BITS-1:0] d;
    logic [PIXEL_BITS-1:0] left;
    t_quad                 q_mid;
    t_quad                 q_cur;
    t_result               res_mid;
    t_result               res_cur;
    t_result               push_data0;
    t_result               push_data1;
    logic                  push0;
    logic                  push1;
    logic                  room2;
    t_result               out_word;
    logic                  cfg_wr;
    t_reg_index            cfg_sel;

    function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(32'(v) - 32'd1);
        end
        return r;
    endfunction

    // register port
    assign pready  = 1'b1;
    assign cfg_sel = t_reg_index'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_sel)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_WIDTH:  r_width  <= pwdata[DIM_REG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w_last = dim_last(r_width);
    assign h_last = dim_last(r_height);

    // window and position logic
    assign s_axis_tready = room2;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign first_row = (r_row == '0);
    assign last_row  = ({1'b0, r_row} >= h_last);
    assign last_col  = ({1'b0, r_col} >= w_last);

    always_comb begin
        e = s_axis_tdata[PIXEL_BITS-1:0];
        a = first_row ? e : s_axis_tdata[PIX_W +: PIXEL_BITS];
        d = last_row  ? e : s_axis_tdata[2*PIX_W +: PIXEL_BITS];
        left = r_window_valid ? r_mid_center : e;

        q_mid = scale2x(PIX_W'(r_mid_center), PIX_W'(r_mid_above), PIX_W'(e),
                        PIX_W'(r_left_center), PIX_W'(r_mid_below));
        q_cur = scale2x(PIX_W'(e), PIX_W'(a), PIX_W'(e), PIX_W'(left), PIX_W'(d));

        res_mid.src_column   = POS_W'(r_col - CNT_W'(1));
        res_mid.src_row      = POS_W'(r_row);
        res_mid.top_left     = q_mid.top_left;
        res_mid.top_right    = q_mid.top_right;
        res_mid.bottom_left  = q_mid.bottom_left;
        res_mid.bottom_right = q_mid.bottom_right;
        res_mid.frame_done   = 1'b0;

        res_cur.src_column   = POS_W'(r_col);
        res_cur.src_row      = POS_W'(r_row);
        res_cur.top_left     = q_cur.top_left;
        res_cur.top_right    = q_cur.top_right;
        res_cur.bottom_left  = q_cur.bottom_left;
        res_cur.bottom_right = q_cur.bottom_right;
        res_cur.frame_done   = last_row;

        push0      = in_acc && (r_window_valid || last_col);
        push1      = in_acc && r_window_valid && last_col;
        push_data0 = r_window_valid ? res_mid : res_cur;
        push_data1 = res_cur;
    end

    always_comb begin
        n_left_center  = r_left_center;
        n_mid_center   = r_mid_center;
        n_mid_above    = r_mid_above;
        n_mid_below    = r_mid_below;
        n_col          = r_col;
        n_row          = r_row;
        n_window_valid = r_window_valid;
        if (in_acc) begin
            if (last_col) begin
                n_window_valid = 1'b0;
                n_col          = '0;
                n_row          = last_row ? '0 : r_row + CNT_W'(1);
            end else begin
                n_left_center  = left;
                n_mid_center   = e;
                n_mid_above    = a;
                n_mid_below    = d;
                n_window_valid = 1'b1;
                n_col          = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_window_valid <= 1'b0;
        end else begin
            r_col          <= n_col;
            r_row          <= n_row;
            r_window_valid <= n_window_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left_center <= n_left_center;
        r_mid_center  <= n_mid_center;
        r_mid_above   <= n_mid_above;
        r_mid_below   <= n_mid_below;
    end

    s2x_result_fifo #(
        .DEPTH (FIFO_DEPTH_C)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (push_data0),
        .i_data1 (push_data1),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_word)
    );

    assign m_axis_tdata = {out_word.bottom_right, out_word.bottom_left, out_word.top_right,
                           out_word.top_left, out_word.src_row, out_word.src_column};
    assign m_axis_tlast = out_word.frame_done;

endmodule

@@ hw/rtl/s2x_result_fifo.sv @@
// small result queue taking up to two words per cycle, one word out per cycle while i_ready is high
module s2x_result_fifo
    import s2x_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_C
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  logic    i_push1,
    input  t_result i_data0,
    input  t_result i_data1,
    output logic    o_room2,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wp1;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room2 = (r_count <= CNT_W'(DEPTH - 2));
    assign wp1     = r_wp + PTR_W'(1);

    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push0) + PTR_W'(i_push1);
        n_rp    = r_rp + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push0) + CNT_W'(i_push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wp1] <= i_data1;
        end
    end

endmodule

@@ verif/tb.sv @@
// testbench for the scale2x 2x pixel upscaler: raster stimulus, reference predictor, result checks
module tb;
    import s2x_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int MAX_GAP      = 17;
    localparam logic [PIX_W-1:0] ALL_ONES = '1;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // center_pixel, above_pixel, below_pixel
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // src_column, src_row, top_left, top_right,
                                           // bottom_left, bottom_right
    logic             m_axis_tlast;        // frame_done
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    // predictor state
    logic [DIM_REG_W-1:0] width_reg = WIDTH_RESET;
    logic [DIM_REG_W-1:0] height_reg = HEIGHT_RESET;
    logic [PIX_W-1:0]     left_pix = '0;
    logic [PIX_W-1:0]     pend_center = '0;
    logic [PIX_W-1:0]     pend_above = '0;
    logic [PIX_W-1:0]     pend_below = '0;
    int                   col_pos = 0;
    int                   row_pos = 0;
    bit                   pend_valid = 1'b0;

    t_result          pending_blocks[$];
    logic [PIX_W-1:0] frame_pix[];
    logic [PIX_W-1:0] palette[3];
    int               error_count = 0;
    int               items_sent = 0;
    int               quiet_cycles = 0;
    bit               send_burst = 1'b0;
    bit               take_burst = 1'b0;

    scale2x_pixel_upscaler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int effective_size(input logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_C) return MAX_DIM_C;
        return int'(v);
    endfunction

    // e centre, a above, b right, c left, d below
    function automatic t_result epx_block(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row,
                                          input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] a,
                                          input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
                                          input logic [PIX_W-1:0] d, input logic done);
        t_result r;
        r.src_column   = col;
        r.src_row      = row;
        r.top_left     = (c == a && c != d && a != b) ? a : e;
        r.top_right    = (a == b && a != c && b != d) ? b : e;
        r.bottom_left  = (d == c && d != b && c != a) ? c : e;
        r.bottom_right = (b == d && b != a && d != c) ? d : e;
        r.frame_done   = done;
        return r;
    endfunction

    task automatic track_pixel(input logic [PIX_W-1:0] center, input logic [PIX_W-1:0] above,
                               input logic [PIX_W-1:0] below);
        int               w;
        int               h;
        bit               last_row;
        bit               last_col;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] left;
        w = effective_size(width_reg);
        h = effective_size(height_reg);
        last_row = (row_pos >= h - 1);
        last_col = (col_pos >= w - 1);
        a = (row_pos == 0) ? center : above;
        d = last_row ? center : below;
        if (pend_valid) begin
            pending_blocks.push_back(epx_block(POS_W'(col_pos - 1), POS_W'(row_pos), pend_center,
                                               pend_above, center, left_pix, pend_below, 1'b0));
            left = pend_center;
        end else begin
            left = center;
        end
        if (last_col) begin
            pending_blocks.push_back(epx_block(POS_W'(col_pos), POS_W'(row_pos), center, a,
                                               center, left, d, last_row));
            pend_valid = 1'b0;
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            left_pix = left;
            pend_center = center;
            pend_above = a;
            pend_below = d;
            pend_valid = 1'b1;
            col_pos = col_pos + 1;
        end
    endtask

    task automatic send_sample(input logic [PIX_W-1:0] center, input logic [PIX_W-1:0] above,
                               input logic [PIX_W-1:0] below);
        int gap;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {below, above, center};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_pixel(center, above, below);
        items_sent++;
    endtask

    task automatic send_random_run(input int n);
        repeat (n) send_sample($urandom, $urandom, $urandom);
    endtask

    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_index idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_WIDTH) width_reg = value[DIM_REG_W-1:0];
        else height_reg = value[DIM_REG_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input t_reg_index idx);
        logic [31:0] want;
        want = (idx == REG_WIDTH) ? 32'(width_reg) : 32'(height_reg);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            if (error_count < 10)
                $display("register %s read: expected %h got %h", idx.name(), want, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got, inout bit bad);
        if (want !== got) begin
            if (error_count < 10) $display("%s: expected %h got %h", name, want, got);
            bad = 1'b1;
        end
    endtask

    task automatic check_block();
        t_result got;
        t_result want;
        bit      bad;
        got = t_result'({m_axis_tlast, m_axis_tdata});
        bad = 1'b0;
        if (pending_blocks.size() == 0) begin
            if (error_count < 10)
                $display("unexpected word: column %0d row %0d", got.src_column, got.src_row);
            error_count++;
        end else begin
            want = pending_blocks.pop_front();
            compare_field("src_column", 32'(want.src_column), 32'(got.src_column), bad);
            compare_field("src_row", 32'(want.src_row), 32'(got.src_row), bad);
            compare_field("top_left", want.top_left, got.top_left, bad);
            compare_field("top_right", want.top_right, got.top_right, bad);
            compare_field("bottom_left", want.bottom_left, got.bottom_left, bad);
            compare_field("bottom_right", want.bottom_right, got.bottom_right, bad);
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done), bad);
            if (bad) error_count++;
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return palette[$urandom_range(0, 2)];
    endfunction

    // neighbours off the image edge get junk, the block must ignore it; with broken set every neighbour is junk
    task automatic feed_raster(input int w, input int h, input int count, input bit broken);
        int               idx;
        int               r;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] below;
        for (idx = 0; idx < count; idx++) begin
            r = idx / w;
            if (r == 0 || broken) above = $urandom;
            else above = frame_pix[idx - w];
            if (r == h - 1 || broken) below = $urandom;
            else below = frame_pix[idx + w];
            send_sample(frame_pix[idx], above, below);
        end
    endtask

    task automatic test_register_access();
        reg_read(REG_WIDTH);
        reg_read(REG_HEIGHT);
        reg_write(REG_WIDTH, 32'hFFFF_E003);
        reg_write(REG_HEIGHT, 32'h0000_0003);
        reg_read(REG_WIDTH);
        reg_read(REG_HEIGHT);
    endtask

    task automatic test_edge_patterns();
        int r;
        int c;
        frame_pix = new[9];
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                frame_pix[r * 3 + c] = (c >= r) ? ALL_ONES : '0;
        feed_raster(3, 3, 9, 1'b0);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                frame_pix[r * 3 + c] = (r + c >= 2) ? ALL_ONES : 32'h5A5A_A5A5;
        feed_raster(3, 3, 9, 1'b0);
        settle_pipeline();
        reg_write(REG_WIDTH, 1);
        reg_write(REG_HEIGHT, 2);
        frame_pix = new[2];
        frame_pix[0] = ALL_ONES;
        frame_pix[1] = '0;
        feed_raster(1, 2, 2, 1'b0);
        settle_pipeline();
    endtask

    task automatic test_size_limits();
        reg_write(REG_WIDTH, 5000);
        reg_write(REG_HEIGHT, 8191);
        reg_read(REG_WIDTH);
        reg_read(REG_HEIGHT);
        send_random_run(6);
        settle_pipeline();
        // shrink below the current position mid-row and mid-frame
        reg_write(REG_WIDTH, 3);
        send_random_run(1);
        settle_pipeline();
        reg_write(REG_HEIGHT, 0);
        send_random_run(3);
        settle_pipeline();
        reg_write(REG_WIDTH, MAX_DIM_C);
        reg_write(REG_HEIGHT, MAX_DIM_C);
        send_random_run(4);
        settle_pipeline();
        reg_write(REG_WIDTH, 0);
        send_random_run(1);
        settle_pipeline();
        reg_write(REG_HEIGHT, 1);
        send_random_run(1);
        settle_pipeline();
    endtask

    task automatic test_random_frames();
        int target;
        int w;
        int h;
        int sel;
        int frames;
        int f;
        int i;
        int count;
        bit broken;
        target = RANDOM_ITEMS;
        while (items_sent < target) begin
            settle_pipeline();
            sel = $urandom_range(0, 99);
            w = (sel < 10) ? 1 : (sel < 25) ? $urandom_range(20, 80) : $urandom_range(2, 9);
            h = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
            reg_write(REG_WIDTH, w);
            reg_write(REG_HEIGHT, h);
            // finish any frame left open so the raster lines up again
            while (col_pos != 0 || row_pos != 0) send_random_run(1);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                palette[0] = $urandom;
                palette[1] = $urandom_range(0, 1) ? ALL_ONES : '0;
                palette[2] = $urandom;
                frame_pix = new[w * h];
                for (i = 0; i < w * h; i++) frame_pix[i] = pick_pixel();
                broken = ($urandom_range(0, 9) == 0);
                count = w * h;
                if (f == frames - 1 && $urandom_range(0, 5) == 0)
                    count = $urandom_range(1, w * h);
                if (count > target - items_sent) count = target - items_sent;
                feed_raster(w, h, count, broken);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_block();
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_edge_patterns();
        test_size_limits();
        test_random_frames();
        settle_pipeline();
        if (error_count == 0 && pending_blocks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/s2x_pkg.sv
hw/rtl/s2x_result_fifo.sv
hw/rtl/scale2x_pixel_upscaler_top.sv
verif/tb.sv
